[src/crcdf_pkg.sv]
package crcdf_pkg;

	localparam int MAX_FRAME = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int HDR_BYTES = 3;
	localparam int FRAME_OVERHEAD = 6;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] status_t;
	typedef logic [0:0] cfg_idx_t;

	localparam status_t ST_PAYLOAD = 2'd0;
	localparam status_t ST_REJECT = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	localparam cfg_idx_t CFG_START_MARKER = 1'd0;
	localparam cfg_idx_t CFG_END_MARKER = 1'd1;

	localparam byte_t START_MARKER_RST = 8'hAA;
	localparam byte_t END_MARKER_RST = 8'hFF;

	// controller to datapath
	typedef struct packed {
		logic    open;
		logic    take;
		logic    rd_issue;
		logic    load_payload;
		logic    load_status;
		status_t code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_hit;
		logic done;
		logic good;
		logic overflow;
		logic rd_last;
		logic out_free;
	} dp_sts_t;

	// reflected crc-32, one byte
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input byte_t b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[src/crcdf_rx_if.sv]
interface crcdf_rx_if;
	logic                valid;
	logic                ready;
	crcdf_pkg::byte_t    rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

[src/crcdf_tx_if.sv]
interface crcdf_tx_if;
	logic                valid;
	logic                ready;
	crcdf_pkg::byte_t    payload_byte;
	logic                is_last;
	crcdf_pkg::status_t  status;

	modport source(output valid, output payload_byte, output is_last, output status,
		input ready);
	modport sink(input valid, input payload_byte, input is_last, input status,
		output ready);
endinterface

[src/crcdf_datapath.sv]
module crcdf_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  crcdf_pkg::cfg_idx_t  cfg_index,
	input  crcdf_pkg::byte_t     cfg_wdata,
	input  crcdf_pkg::byte_t     rx_byte,
	input  crcdf_pkg::dp_cmd_t   cmd,
	output crcdf_pkg::dp_sts_t   sts,
	output logic                 tx_valid,
	input  logic                 tx_ready,
	output crcdf_pkg::byte_t     tx_byte,
	output logic                 tx_is_last,
	output crcdf_pkg::status_t   tx_status
);
	import crcdf_pkg::*;

	byte_t start_q;
	byte_t end_q;

	logic [CNT_W-1:0] cnt_q;
	byte_t            len_q;
	logic [31:0]      crc_q;
	byte_t            chk_q;

	byte_t            mem [STORE_DEPTH];
	byte_t            rdata_q;
	logic [ADDR_W-1:0] rd_k_q;

	logic    out_valid_q;
	byte_t   out_byte_q;
	logic    out_last_q;
	status_t out_status_q;

	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  cnt_nx;
	byte_t             len_nx;
	logic              feed;
	logic              chk_hit;
	logic [ADDR_W-1:0] wr_addr;
	logic              done;
	logic              out_free;

	always_comb begin
		pos = cnt_q;
		cnt_nx = cnt_q + CNT_W'(1);
		len_nx = (pos == CNT_W'(HDR_BYTES)) ? rx_byte : len_q;
		feed = (pos <= CNT_W'(HDR_BYTES))
			|| ({2'b0, pos} <= ({1'b0, len_nx} + 9'(HDR_BYTES)));
		chk_hit = (pos >= CNT_W'(HDR_BYTES + 1))
			&& ({2'b0, pos} == ({1'b0, len_nx} + 9'(HDR_BYTES + 1)));
		wr_addr = ADDR_W'(pos - CNT_W'(1));
		done = (cnt_nx >= CNT_W'(HDR_BYTES + 1))
			&& ({2'b0, cnt_nx} == ({1'b0, len_nx} + 9'(FRAME_OVERHEAD)));
		out_free = !out_valid_q || tx_ready;
	end

	assign sts.start_hit = (rx_byte == start_q);
	assign sts.done = done;
	// crc and checksum are both settled before the end byte arrives
	assign sts.good = (rx_byte == end_q) && (~crc_q[7:0] == chk_q);
	assign sts.overflow = !done && (cnt_nx >= CNT_W'(MAX_FRAME));
	assign sts.rd_last = ({3'b0, rd_k_q} == ({1'b0, len_q} + 9'(HDR_BYTES - 1)));
	assign sts.out_free = out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_q <= cfg_wdata;
				CFG_END_MARKER:   end_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
			crc_q <= CRC_ALL_ONES;
			chk_q <= '0;
			rd_k_q <= '0;
		end else begin
			if (cmd.open) begin
				cnt_q <= CNT_W'(1);
				len_q <= '0;
				crc_q <= CRC_ALL_ONES;
				chk_q <= '0;
				rd_k_q <= '0;
			end else if (cmd.take) begin
				cnt_q <= cnt_nx;
				len_q <= len_nx;
				if (feed) begin
					crc_q <= crc_feed(crc_q, rx_byte);
				end else if (chk_hit) begin
					chk_q <= rx_byte;
				end
			end else if (cmd.load_payload) begin
				rd_k_q <= rd_k_q + ADDR_W'(1);
			end
		end
	end

	// payload store
	always_ff @(posedge clk) begin
		if (cmd.take && feed) begin
			mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_k_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_payload || cmd.load_status) begin
			out_valid_q <= 1'b1;
		end else if (tx_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_payload) begin
			out_byte_q <= rdata_q;
			out_last_q <= sts.rd_last;
			out_status_q <= ST_PAYLOAD;
		end else if (cmd.load_status) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_status_q <= cmd.code;
		end
	end

	assign tx_valid = out_valid_q;
	assign tx_byte = out_byte_q;
	assign tx_is_last = out_last_q;
	assign tx_status = out_status_q;

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_payload && cmd.load_status))
		else $error("payload and status loaded together");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_payload || cmd.load_status) |-> out_free)
		else $error("output register overwritten before transaction");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME))
		else $error("byte count beyond frame limit");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_status |=> (tx_valid && tx_is_last && tx_byte == '0
			&& tx_status != ST_PAYLOAD))
		else $error("malformed status result");

endmodule

[src/crcdf_ctrl.sv]
module crcdf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_ready,
	input  crcdf_pkg::dp_sts_t  sts,
	output crcdf_pkg::dp_cmd_t  cmd
);
	import crcdf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FRAME = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_WR    = 3'd3;
	localparam logic [2:0] S_REJ   = 3'd4;
	localparam logic [2:0] S_OVF   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       accept;

	assign rx_ready = (state_q == S_IDLE) || (state_q == S_FRAME);
	assign accept = rx_valid && rx_ready;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && sts.start_hit) begin
					cmd.open = 1'b1;
					state_nx = S_FRAME;
				end
			end
			S_FRAME: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (sts.done) begin
						state_nx = sts.good ? S_RD : S_REJ;
					end else if (sts.overflow) begin
						state_nx = S_OVF;
					end
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_nx = S_WR;
			end
			S_WR: begin
				if (sts.out_free) begin
					cmd.load_payload = 1'b1;
					state_nx = sts.rd_last ? S_IDLE : S_RD;
				end
			end
			S_REJ: begin
				cmd.code = ST_REJECT;
				if (sts.out_free) begin
					cmd.load_status = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_OVF: begin
				cmd.code = ST_OVERFLOW;
				if (sts.out_free) begin
					cmd.load_status = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_no_take_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue || cmd.load_payload || cmd.load_status) |-> !rx_ready)
		else $error("input taken while results pending");

	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> (state_q == S_WR))
		else $error("read data not followed by output load");

	a_open_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.open |=> (state_q == S_FRAME))
		else $error("frame open did not enter frame state");

endmodule

[src/crc_checked_frame_deframer.sv]
// Frame receiver: takes one byte per rx transaction. While idle every byte
// other than the start marker is dropped. A frame is start, command, function,
// length, length data bytes, checksum, end (length+6 bytes); the checksum must
// match the low byte of the reflected crc-32 over command..last data byte and
// the end byte must match end_marker. A good frame is delivered on tx as its
// command..last data bytes (status 0, is_last on the final one); a bad frame
// gives one reject status (1) and a frame reaching 64 bytes unfinished gives one
// overflow status (2). After a good frame the input stalls while the payload
// is read back from the 64-entry payload store, each byte by a store read and
// then an output register load that waits for the output register to be free.
// Results wait in a single output register, and an input byte can be taken
// while a status result is still waiting there.
module crc_checked_frame_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  crcdf_pkg::cfg_idx_t  cfg_index,
	input  crcdf_pkg::byte_t     cfg_wdata,
	crcdf_rx_if.sink             rx,
	crcdf_tx_if.source           tx
);
	import crcdf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	crcdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crcdf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.rx_byte    (rx.rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.tx_valid   (tx.valid),
		.tx_ready   (tx.ready),
		.tx_byte    (tx.payload_byte),
		.tx_is_last (tx.is_last),
		.tx_status  (tx.status)
	);

endmodule
